@@ hdl/rsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared sizes, function and status codes, state types and the control
// structs passed between the core and its serial arithmetic unit.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // Sizes
  localparam int STACK_DEPTH   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W         = $clog2(STACK_DEPTH);
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ITER_W        = $clog2(DATA_W + 2);
  localparam int RND_IDX       = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Function codes (5 to 7 are no-ops)
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_FULL    = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  // Core sequencer states
  typedef enum logic [2:0] {
    C_IDLE,
    C_RD_A,
    C_CHK,
    C_WAIT,
    C_RD_TOP,
    C_OUT
  } ctrl_state_t;

  // Arithmetic unit states
  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_MUL,
    A_MRND,
    A_DIV,
    A_FIN
  } alu_state_t;

  // Core to arithmetic unit
  typedef struct packed {
    logic  start;
    func_t op;
  } alu_req_t;

  // Arithmetic unit to core
  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

endpackage

@@ hdl/rsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator channels
// Valid/ready channels for input commands and for results.
// ----------------------------------------------------------------------------

// Command channel
interface rsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rsc_pkg::FUNC_W-1:0]          func;
  logic signed [rsc_pkg::DATA_W-1:0]   operand_value;

  modport source (output valid, output func, output operand_value, input ready);
  modport sink   (input valid, input func, input operand_value, output ready);
endinterface

// Result channel
interface rsc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::DATA_W-1:0]   top_value;
  logic [rsc_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output top_value, output status, input ready);
  modport sink   (input valid, input top_value, input status, output ready);
endinterface

@@ hdl/rsc_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator serial arithmetic unit
// Bit-serial add/subtract, shift-add multiply and restoring divide on
// signed fixed-point words, one bit per cycle, with rounding and saturation.
// ----------------------------------------------------------------------------
module rsc_alu (
  input  logic                               clk,
  input  logic                               rst,
  input  rsc_pkg::alu_req_t                  req,
  input  logic signed [rsc_pkg::DATA_W-1:0]  opa,
  input  logic signed [rsc_pkg::DATA_W-1:0]  opb,
  output rsc_pkg::alu_rsp_t                  rsp,
  output logic [rsc_pkg::DATA_W-1:0]         result
);

  localparam int DW = rsc_pkg::DATA_W;
  localparam int PW = rsc_pkg::PROD_W;
  localparam int IW = rsc_pkg::ITER_W;

  rsc_pkg::alu_state_t state, state_next;
  rsc_pkg::func_t      op;

  logic [DW:0]   x;       // serial addend a / multiplicand
  logic [DW:0]   y;       // serial addend b / divisor magnitude
  logic          carry;
  logic [DW:0]   rem;     // serial sum / division remainder
  logic [PW-1:0] prod;    // product / dividend low and quotient
  logic [IW-1:0] iter;
  logic          neg;
  logic          ovf;
  logic          done;
  logic          sat;

  // Operand magnitudes for the divider
  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [PW-1:0] num_mag;

  // Serial add bit
  logic          add_bit;
  logic          add_cy;

  // Multiply step
  logic          mul_last;
  logic [DW:0]   mul_addend;
  logic [DW:0]   mul_sum;
  logic          rnd_bit;

  // Divide step
  logic [DW:0]   div_shift;
  logic [DW:0]   div_trial;

  // Final result selection
  logic [DW-1:0] fin_res;
  logic          fin_sat;

  assign mag_a   = opa[DW-1] ? (~opa + DW'(1)) : opa;
  assign mag_b   = opb[DW-1] ? (~opb + DW'(1)) : opb;
  assign num_mag = PW'(mag_a) << rsc_pkg::FRACTION_BITS;

  assign add_bit = x[0] ^ y[0] ^ carry;
  assign add_cy  = (x[0] & y[0]) | (x[0] & carry) | (y[0] & carry);

  // Last multiplier bit carries negative weight
  assign mul_last   = (iter == IW'(DW - 1));
  assign mul_addend = prod[0] ? (mul_last ? ~x : x) : '0;
  assign mul_sum    = {prod[PW-1], prod[PW-1:DW]} + mul_addend
                      + {{DW{1'b0}}, prod[0] & mul_last};
  assign rnd_bit    = (rsc_pkg::FRACTION_BITS > 0) && prod[rsc_pkg::RND_IDX];

  assign div_shift = {rem[DW-1:0], prod[DW-1]};
  assign div_trial = div_shift - y;

  // Saturate per operation
  always_comb begin
    fin_res = rsc_pkg::SAT_MAX;
    fin_sat = 1'b0;
    case (op)
      rsc_pkg::FN_ADD, rsc_pkg::FN_SUB: begin
        fin_sat = rem[DW] ^ rem[DW-1];
        fin_res = fin_sat ? (rem[DW] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX)
                          : rem[DW-1:0];
      end
      rsc_pkg::FN_MUL: begin
        fin_sat = (prod[PW-1:DW-1] != {(DW+1){prod[PW-1]}});
        fin_res = fin_sat ? (prod[PW-1] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX)
                          : prod[DW-1:0];
      end
      rsc_pkg::FN_DIV: begin
        if (ovf) begin
          fin_sat = 1'b1;
          fin_res = neg ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX;
        end else if (!neg) begin
          fin_sat = prod[DW-1];
          fin_res = fin_sat ? rsc_pkg::SAT_MAX : prod[DW-1:0];
        end else begin
          fin_sat = prod[DW-1:0] > rsc_pkg::SAT_MIN;
          fin_res = fin_sat ? rsc_pkg::SAT_MIN : (~prod[DW-1:0] + DW'(1));
        end
      end
      default: begin
        fin_res = rsc_pkg::SAT_MAX;
        fin_sat = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rsc_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            rsc_pkg::FN_ADD, rsc_pkg::FN_SUB: state_next = rsc_pkg::A_ADD;
            rsc_pkg::FN_MUL:                  state_next = rsc_pkg::A_MUL;
            rsc_pkg::FN_DIV:                  state_next = rsc_pkg::A_DIV;
            default:                          state_next = rsc_pkg::A_IDLE;
          endcase
        end
      end
      rsc_pkg::A_ADD:  if (iter == IW'(DW)) state_next = rsc_pkg::A_FIN;
      rsc_pkg::A_MUL:  if (mul_last) state_next = rsc_pkg::A_MRND;
      rsc_pkg::A_MRND: state_next = rsc_pkg::A_FIN;
      rsc_pkg::A_DIV:  if (iter == IW'(DW - 1)) state_next = rsc_pkg::A_FIN;
      rsc_pkg::A_FIN:  state_next = rsc_pkg::A_IDLE;
      default:         state_next = rsc_pkg::A_IDLE;
    endcase
  end

  // Completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == rsc_pkg::A_FIN);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      rsc_pkg::A_IDLE: begin
        if (req.start) begin
          op    <= req.op;
          iter  <= '0;
          neg   <= opa[DW-1] ^ opb[DW-1];
          ovf   <= num_mag[PW-1:DW] >= mag_b;
          x     <= {opa[DW-1], opa};
          carry <= (req.op == rsc_pkg::FN_SUB);
          if (req.op == rsc_pkg::FN_DIV) begin
            y    <= {1'b0, mag_b};
            rem  <= {1'b0, num_mag[PW-1:DW]};
            prod <= {{DW{1'b0}}, num_mag[DW-1:0]};
          end else begin
            y    <= (req.op == rsc_pkg::FN_SUB) ? ~{opb[DW-1], opb} : {opb[DW-1], opb};
            rem  <= '0;
            prod <= {{DW{1'b0}}, opb};
          end
        end
      end
      rsc_pkg::A_ADD: begin
        carry <= add_cy;
        x     <= {1'b0, x[DW:1]};
        y     <= {1'b0, y[DW:1]};
        rem   <= {add_bit, rem[DW:1]};
        iter  <= iter + IW'(1);
      end
      rsc_pkg::A_MUL: begin
        prod <= {mul_sum, prod[DW-1:1]};
        iter <= iter + IW'(1);
      end
      rsc_pkg::A_MRND: begin
        // floor shift, plus the bit below the point: round half up
        prod <= PW'($signed(prod) >>> rsc_pkg::FRACTION_BITS)
                + {{(PW-1){1'b0}}, rnd_bit};
      end
      rsc_pkg::A_DIV: begin
        rem  <= div_trial[DW] ? div_shift : div_trial;
        prod <= {prod[PW-1:DW], prod[DW-2:0], ~div_trial[DW]};
        iter <= iter + IW'(1);
      end
      rsc_pkg::A_FIN: begin
        result <= fin_res;
        sat    <= fin_sat;
      end
      default: begin
        iter <= iter;
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.sat  = sat;

endmodule

@@ hdl/rpn_stack_calculator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Reverse Polish calculator over a bounded stack of signed Q16.16 values.
// Sequences stack reads/writes and hands operators to a serial arithmetic
// unit; every command returns the new top value and a status.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                        | Handshake
//  --------+-----+--------------------------------+------------
//  req     | in  | func[2:0], operand_value[31:0] | valid/ready
//  rsp     | out | top_value[31:0], status[1:0]   | valid/ready
//
//  Push, dropped push, no-op and divide by zero need no arithmetic unit; add,
//  subtract, multiply and other divides run through the one-bit-per-cycle
//  loops of the arithmetic unit (33 add/subtract steps, 32 multiply steps
//  plus a rounding step, 32 divide steps). One command is in work at a time;
//  req.ready is high only while the sequencer is idle. A stalled rsp holds
//  the next result in the sequencer until taken.
//  Synchronous reset empties the stack; stack words are not cleared.
//
module rpn_stack_calculator_core (
  input  logic       clk,
  input  logic       rst,
  rsc_in_if.sink     req,
  rsc_out_if.source  rsp
);

  localparam int DW = rsc_pkg::DATA_W;
  localparam int CW = rsc_pkg::CNT_W;
  localparam int AW = rsc_pkg::PTR_W;

  rsc_pkg::ctrl_state_t state, state_next;

  logic [CW-1:0]            count;
  logic [rsc_pkg::FUNC_W-1:0] func_r;
  logic [DW-1:0]            b_r;
  logic [DW-1:0]            top_r;
  rsc_pkg::status_t         status_r;

  // Output register
  logic                     out_valid;
  logic [DW-1:0]            out_top;
  rsc_pkg::status_t         out_status;
  logic                     out_load;

  // Stack memory
  logic [DW-1:0]            mem [rsc_pkg::STACK_DEPTH];
  logic [AW-1:0]            rd_addr;
  logic [DW-1:0]            rd_data;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DW-1:0]            mem_wdata;

  // Stack pointers
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  logic [CW-1:0]            cnt_base;
  logic                     full;
  logic [DW-1:0]            a_val;
  logic                     div_zero;

  // Arithmetic unit
  rsc_pkg::alu_req_t        alu_req;
  rsc_pkg::alu_rsp_t        alu_rsp;
  logic [DW-1:0]            alu_result;

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign cnt_base = (count >= CW'(2)) ? cnt_m2 : '0;
  assign full     = (count >= CW'(rsc_pkg::STACK_DEPTH));
  assign a_val    = (count > CW'(1)) ? rd_data : '0;
  assign div_zero = (func_r == rsc_pkg::FN_DIV) && (b_r == '0);
  assign out_load = (state == rsc_pkg::C_OUT) && (!out_valid || rsp.ready);

  rsc_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (a_val),
    .opb    (b_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake, memory and ALU controls
  always_comb begin
    state_next    = state;
    req.ready     = 1'b0;
    rd_addr       = cnt_m1[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = count[AW-1:0];
    mem_wdata     = req.operand_value;
    alu_req.start = 1'b0;
    alu_req.op    = rsc_pkg::func_t'(func_r);
    case (state)
      rsc_pkg::C_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.func)
            rsc_pkg::FN_PUSH: begin
              if (full) begin
                state_next = rsc_pkg::C_RD_TOP;
              end else begin
                mem_we     = 1'b1;
                state_next = rsc_pkg::C_OUT;
              end
            end
            rsc_pkg::FN_ADD, rsc_pkg::FN_SUB,
            rsc_pkg::FN_MUL, rsc_pkg::FN_DIV: state_next = rsc_pkg::C_RD_A;
            default:                          state_next = rsc_pkg::C_RD_TOP;
          endcase
        end
      end
      rsc_pkg::C_RD_A: begin
        rd_addr    = cnt_m2[AW-1:0];
        state_next = rsc_pkg::C_CHK;
      end
      rsc_pkg::C_CHK: begin
        if (div_zero) begin
          state_next = rsc_pkg::C_OUT;
        end else begin
          alu_req.start = 1'b1;
          state_next    = rsc_pkg::C_WAIT;
        end
      end
      rsc_pkg::C_WAIT: begin
        mem_waddr = cnt_base[AW-1:0];
        mem_wdata = alu_result;
        if (alu_rsp.done) begin
          mem_we     = 1'b1;
          state_next = rsc_pkg::C_OUT;
        end
      end
      rsc_pkg::C_RD_TOP: state_next = rsc_pkg::C_OUT;
      rsc_pkg::C_OUT:    if (out_load) state_next = rsc_pkg::C_IDLE;
      default:           state_next = rsc_pkg::C_IDLE;
    endcase
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == rsc_pkg::C_IDLE && req.valid &&
                 req.func == rsc_pkg::FN_PUSH && !full) begin
      count <= count + CW'(1);
    end else if (state == rsc_pkg::C_WAIT && alu_rsp.done) begin
      count <= cnt_base + CW'(1);
    end
  end

  // Command payload and result staging
  always_ff @(posedge clk) begin
    case (state)
      rsc_pkg::C_IDLE: begin
        if (req.valid) begin
          func_r   <= req.func;
          top_r    <= req.operand_value;
          status_r <= (req.func == rsc_pkg::FN_PUSH && full) ? rsc_pkg::ST_FULL
                                                              : rsc_pkg::ST_OK;
        end
      end
      rsc_pkg::C_RD_A: begin
        b_r <= (count != '0) ? rd_data : '0;
      end
      rsc_pkg::C_CHK: begin
        // divide by zero: stack untouched, top is the zero divisor
        if (div_zero) begin
          top_r    <= b_r;
          status_r <= rsc_pkg::ST_DIVZERO;
        end
      end
      rsc_pkg::C_WAIT: begin
        if (alu_rsp.done) begin
          top_r    <= alu_result;
          status_r <= alu_rsp.sat ? rsc_pkg::ST_SAT : rsc_pkg::ST_OK;
        end
      end
      rsc_pkg::C_RD_TOP: begin
        top_r <= (count != '0) ? rd_data : '0;
      end
      default: begin
        top_r <= top_r;
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_top    <= top_r;
      out_status <= status_r;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.top_value = out_top;
  assign rsp.status    = out_status;

endmodule
